// ----- src/nhc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhc_pkg
// Shared types and constants of the network header checker: frame snapshot,
// result record, status and frame kind codes.
// ----------------------------------------------------------------------------
package nhc_pkg;

  localparam int HEADER_BYTES = 15;
  localparam int ASDU_BYTES   = 4;
  localparam int COUNT_W      = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [7:0]         START_BYTE  = 8'h68;
  localparam logic [COUNT_W-1:0] LEN_OFFSET  = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] FIXED_LEN   = COUNT_W'(HEADER_BYTES);

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_TOO_LONG  = 4'd2,
    ST_BAD_START = 4'd3,
    ST_U_NONE    = 4'd4,
    ST_U_MULTI   = 4'd5,
    ST_U_LEN     = 4'd6,
    ST_U_CTRL    = 4'd7,
    ST_S_CTRL0   = 4'd8,
    ST_S_CTRL1   = 4'd9,
    ST_ODD_RX    = 4'd10,
    ST_S_LEN     = 4'd11,
    ST_I_LEN     = 4'd12
  } nhc_status_t;

  typedef enum logic [1:0] {
    KIND_I = 2'd0,
    KIND_S = 2'd1,
    KIND_U = 2'd2
  } nhc_kind_t;

  // Complete view of one message as it stood at its last byte.
  typedef struct packed {
    logic [COUNT_W-1:0]                cnt;
    logic [HEADER_BYTES-1:0][7:0]      hdr;
    logic [ASDU_BYTES-1:0][7:0]        asdu;
  } nhc_frame_t;

  typedef struct packed {
    nhc_status_t  status;
    nhc_kind_t    frame_kind;
    logic [14:0]  send_seq;
    logic [14:0]  recv_seq;
    logic [5:0]   u_function;
    logic [7:0]   source_station;
    logic [15:0]  source_device;
    logic [7:0]   dest_station;
    logic [15:0]  dest_device;
    logic [7:0]   asdu_type;
    logic [7:0]   asdu_cause;
    logic [7:0]   asdu_common_addr;
  } nhc_result_t;

endpackage
`default_nettype wire

// ----- src/nhc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhc_in_if
// Byte stream channel: one message byte per transfer, last byte flagged.
// ----------------------------------------------------------------------------
interface nhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- src/nhc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhc_out_if
// Result channel: one decoded header report per transfer.
// ----------------------------------------------------------------------------
interface nhc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [1:0]  frame_kind;
  logic [14:0] send_seq;
  logic [14:0] recv_seq;
  logic [5:0]  u_function;
  logic [7:0]  source_station;
  logic [15:0] source_device;
  logic [7:0]  dest_station;
  logic [15:0] dest_device;
  logic [7:0]  asdu_type;
  logic [7:0]  asdu_cause;
  logic [7:0]  asdu_common_addr;

  modport source (
    output valid, output status, output frame_kind, output send_seq, output recv_seq,
    output u_function, output source_station, output source_device, output dest_station,
    output dest_device, output asdu_type, output asdu_cause, output asdu_common_addr,
    input ready
  );
  modport sink (
    input valid, input status, input frame_kind, input send_seq, input recv_seq,
    input u_function, input source_station, input source_device, input dest_station,
    input dest_device, input asdu_type, input asdu_cause, input asdu_common_addr,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/nhc_capture.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhc_capture
// Counts the bytes of a message, keeps the header and ASDU head bytes and
// registers a complete snapshot of the message at its last byte.
// ----------------------------------------------------------------------------
module nhc_capture
  import nhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       valid,
  output logic            ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       frame_take,
  output logic            frame_valid,
  output nhc_frame_t      frame
);

  logic [COUNT_W-1:0]           byte_count;
  logic [COUNT_W-1:0]           byte_count_next;
  logic [HEADER_BYTES-1:0][7:0] header;
  logic [HEADER_BYTES-1:0][7:0] header_next;
  logic [ASDU_BYTES-1:0][7:0]   asdu;
  logic [ASDU_BYTES-1:0][7:0]   asdu_next;
  logic                         accept;

  assign ready  = !frame_valid || frame_take;
  assign accept = valid && ready;

  assign byte_count_next = (byte_count == COUNT_MAX) ? byte_count
                                                     : byte_count + 1'b1;

  // The incoming byte is merged in, so the snapshot already holds it.
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      header_next[i] = (byte_count == COUNT_W'(i)) ? data_byte : header[i];
    end
    for (int i = 0; i < ASDU_BYTES; i++) begin
      asdu_next[i] = (byte_count == COUNT_W'(HEADER_BYTES + i)) ? data_byte : asdu[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      asdu        <= '0;
      frame_valid <= 1'b0;
    end else begin
      frame_valid <= (accept && last_byte) || (frame_valid && !frame_take);
      if (accept) begin
        if (last_byte) begin
          byte_count <= '0;
          asdu       <= '0;
        end else begin
          byte_count <= byte_count_next;
          asdu       <= asdu_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      header <= header_next;
      if (last_byte) begin
        frame.cnt  <= byte_count_next;
        frame.hdr  <= header_next;
        frame.asdu <= asdu_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (byte_count == '0 && asdu == '0))
    else $error("byte count not cleared after last byte");

  a_snapshot_nonzero: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame.cnt != '0))
    else $error("snapshot holds an empty message");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !ready |-> (frame_valid && !frame_take))
    else $error("input stalled with free snapshot register");
`endif

endmodule
`default_nettype wire

// ----- src/nhc_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhc_decode
// Checks and decodes a message snapshot and holds the result in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module nhc_decode
  import nhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       frame_valid,
  input  wire nhc_frame_t frame,
  output logic            frame_take,
  input  wire logic       out_ready,
  output logic            result_valid,
  output nhc_result_t     result
);

  nhc_result_t        decoded;
  logic [COUNT_W-1:0] declared;
  logic [7:0]         c0;
  logic [7:0]         c1;
  logic [7:0]         c2;
  logic [7:0]         c3;
  logic [5:0]         ufn;

  assign frame_take = frame_valid && (!result_valid || out_ready);

  assign declared = {1'b0, frame.hdr[2], frame.hdr[1]} + LEN_OFFSET;
  assign c0  = frame.hdr[3];
  assign c1  = frame.hdr[4];
  assign c2  = frame.hdr[5];
  assign c3  = frame.hdr[6];
  assign ufn = c0[7:2];

  always_comb begin
    decoded = '0;
    if (frame.cnt < FIXED_LEN) begin
      decoded.status = ST_SHORT;
    end else if (frame.hdr[0] != START_BYTE) begin
      decoded.status = ST_BAD_START;
    end else if (declared > frame.cnt) begin
      decoded.status = ST_TOO_LONG;
    end else begin
      if (c0[0]) begin
        if (c0[1]) begin
          decoded.frame_kind = KIND_U;
          decoded.u_function = ufn;
          if (ufn == '0)                         decoded.status = ST_U_NONE;
          else if (!$onehot(ufn))                decoded.status = ST_U_MULTI;
          else if (declared != FIXED_LEN)        decoded.status = ST_U_LEN;
          else if (c1 != '0 || c2 != '0 || c3 != '0) decoded.status = ST_U_CTRL;
        end else begin
          decoded.frame_kind = KIND_S;
          decoded.recv_seq   = {c3, c2[7:1]};
          if (c0 != 8'h01)                decoded.status = ST_S_CTRL0;
          else if (c1 != '0)              decoded.status = ST_S_CTRL1;
          else if (c2[0])                 decoded.status = ST_ODD_RX;
          else if (declared != FIXED_LEN) decoded.status = ST_S_LEN;
        end
      end else begin
        decoded.frame_kind = KIND_I;
        decoded.send_seq   = {c1, c0[7:1]};
        decoded.recv_seq   = {c3, c2[7:1]};
        if (c2[0])                       decoded.status = ST_ODD_RX;
        else if (declared <= FIXED_LEN)  decoded.status = ST_I_LEN;
      end
      decoded.source_station   = frame.hdr[7];
      decoded.source_device    = {frame.hdr[9], frame.hdr[8]};
      decoded.dest_station     = frame.hdr[10];
      decoded.dest_device      = {frame.hdr[12], frame.hdr[11]};
      decoded.asdu_type        = frame.asdu[0];
      decoded.asdu_cause       = frame.asdu[2];
      decoded.asdu_common_addr = frame.asdu[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (frame_take) begin
      result_valid <= 1'b1;
    end else if (out_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      result <= decoded;
    end
  end

`ifndef SYNTHESIS
  a_early_error_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == ST_SHORT || result.status == ST_TOO_LONG ||
                      result.status == ST_BAD_START))
    |-> (result.frame_kind == KIND_I && result.recv_seq == '0 && result.asdu_type == '0))
    else $error("early error result carries decoded fields");

  a_ufn_only_u: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_kind != KIND_U) |-> (result.u_function == '0))
    else $error("function bits reported outside a U frame");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !out_ready) |=> (result_valid && $stable(result)))
    else $error("waiting result changed before its transfer");
`endif

endmodule
`default_nettype wire

// ----- src/iec103_net_header_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Path: the snapshot register is written at the transfer of the last byte of a
//   message, and the result register from it once the result register can take it.
// Throughput: one byte per cycle; the input stalls only while both the
//   snapshot and the result register hold a report that is not yet taken.
// Reset: synchronous rst clears the byte count, the ASDU head and both valids.
// ----------------------------------------------------------------------------
// iec103_net_header_checker
// Captures one network message byte by byte and reports the checked APCI
// header, addresses and ASDU head at its last byte.
// ----------------------------------------------------------------------------
module iec103_net_header_checker
  import nhc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  nhc_in_if.sink    capture,
  nhc_out_if.source report
);

  nhc_frame_t  frame;
  nhc_result_t result;
  logic        frame_valid;
  logic        frame_take;

  nhc_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .valid       (capture.valid),
    .ready       (capture.ready),
    .data_byte   (capture.data_byte),
    .last_byte   (capture.last_byte),
    .frame_take  (frame_take),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  nhc_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame        (frame),
    .frame_take   (frame_take),
    .out_ready    (report.ready),
    .result_valid (report.valid),
    .result       (result)
  );

  assign report.status           = result.status;
  assign report.frame_kind       = result.frame_kind;
  assign report.send_seq         = result.send_seq;
  assign report.recv_seq         = result.recv_seq;
  assign report.u_function       = result.u_function;
  assign report.source_station   = result.source_station;
  assign report.source_device    = result.source_device;
  assign report.dest_station     = result.dest_station;
  assign report.dest_device      = result.dest_device;
  assign report.asdu_type        = result.asdu_type;
  assign report.asdu_cause       = result.asdu_cause;
  assign report.asdu_common_addr = result.asdu_common_addr;

endmodule
`default_nettype wire

// ----- sim/nhc_report_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhc_report_checker
// Watches the byte and report channels of the network header checker, keeps
// its own copy of the captured message, works out the report due at each
// last byte and compares every report transfer with the oldest one due.
// ----------------------------------------------------------------------------
module nhc_report_checker
  import nhc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  nhc_in_if         capture,
  nhc_out_if        report,
  output int        mismatches,
  output int        outstanding
);

  localparam logic [7:0] S_CTRL_BYTE = 8'h01;

  logic [COUNT_W-1:0] byte_total;
  logic [7:0]         hdr_bytes  [HEADER_BYTES];
  logic [7:0]         asdu_bytes [ASDU_BYTES];
  nhc_result_t        expected_reports [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Decodes the message held so far, as the block does at its last byte.
  function automatic nhc_result_t decode_message();
    nhc_result_t        r;
    logic [COUNT_W-1:0] declared;
    logic [7:0]         c0, c1, c2, c3;
    int                 ones;
    r = '0;
    if (byte_total < FIXED_LEN) begin
      r.status = ST_SHORT;
    end else if (hdr_bytes[0] != START_BYTE) begin
      r.status = ST_BAD_START;
    end else begin
      declared = {1'b0, hdr_bytes[2], hdr_bytes[1]} + LEN_OFFSET;
      if (declared > byte_total) begin
        r.status = ST_TOO_LONG;
      end else begin
        c0 = hdr_bytes[3];
        c1 = hdr_bytes[4];
        c2 = hdr_bytes[5];
        c3 = hdr_bytes[6];
        r.status = ST_OK;
        if (c0[0]) begin
          if (c0[1]) begin
            ones = $countones(c0[7:2]);
            r.frame_kind = KIND_U;
            r.u_function = c0[7:2];
            if (ones == 0) r.status = ST_U_NONE;
            else if (ones > 1) r.status = ST_U_MULTI;
            else if (declared != FIXED_LEN) r.status = ST_U_LEN;
            else if ((c1 | c2 | c3) != 8'h00) r.status = ST_U_CTRL;
          end else begin
            r.frame_kind = KIND_S;
            r.recv_seq = {c3, c2[7:1]};
            if (c0 != S_CTRL_BYTE) r.status = ST_S_CTRL0;
            else if (c1 != 8'h00) r.status = ST_S_CTRL1;
            else if (c2[0]) r.status = ST_ODD_RX;
            else if (declared != FIXED_LEN) r.status = ST_S_LEN;
          end
        end else begin
          r.frame_kind = KIND_I;
          r.send_seq = {c1, c0[7:1]};
          r.recv_seq = {c3, c2[7:1]};
          if (c2[0]) r.status = ST_ODD_RX;
          else if (declared <= FIXED_LEN) r.status = ST_I_LEN;
        end
        r.source_station   = hdr_bytes[7];
        r.source_device    = {hdr_bytes[9], hdr_bytes[8]};
        r.dest_station     = hdr_bytes[10];
        r.dest_device      = {hdr_bytes[12], hdr_bytes[11]};
        r.asdu_type        = asdu_bytes[0];
        r.asdu_cause       = asdu_bytes[2];
        r.asdu_common_addr = asdu_bytes[3];
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      note_failure($sformatf("report field %s: expected %0h, got %0h", name, want, got));
  endtask

  task automatic compare_report();
    nhc_result_t want;
    if (expected_reports.size() == 0) begin
      note_failure($sformatf("report transfer with nothing due, status %0h",
                             report.status));
      return;
    end
    want = expected_reports.pop_front();
    check_field("status", want.status, report.status);
    check_field("frame_kind", want.frame_kind, report.frame_kind);
    check_field("send_seq", want.send_seq, report.send_seq);
    check_field("recv_seq", want.recv_seq, report.recv_seq);
    check_field("u_function", want.u_function, report.u_function);
    check_field("source_station", want.source_station, report.source_station);
    check_field("source_device", want.source_device, report.source_device);
    check_field("dest_station", want.dest_station, report.dest_station);
    check_field("dest_device", want.dest_device, report.dest_device);
    check_field("asdu_type", want.asdu_type, report.asdu_type);
    check_field("asdu_cause", want.asdu_cause, report.asdu_cause);
    check_field("asdu_common_addr", want.asdu_common_addr, report.asdu_common_addr);
  endtask

  // Both channels are sampled at the rising edge; inputs only move on the
  // falling edge, so the values seen here are the ones the block took.
  always @(posedge clk) begin
    if (rst) begin
      byte_total = '0;
      asdu_bytes = '{default: 8'h00};
    end else begin
      if (report.valid === 1'b1 && report.ready === 1'b1) compare_report();
      if (capture.valid === 1'b1 && capture.ready === 1'b1) begin
        if (byte_total < HEADER_BYTES)
          hdr_bytes[byte_total] = capture.data_byte;
        else if (byte_total < HEADER_BYTES + ASDU_BYTES)
          asdu_bytes[byte_total - HEADER_BYTES] = capture.data_byte;
        if (byte_total != COUNT_MAX) byte_total++;
        if (capture.last_byte) begin
          expected_reports.push_back(decode_message());
          byte_total = '0;
          asdu_bytes = '{default: 8'h00};
        end
      end
    end
    outstanding = expected_reports.size();
  end

endmodule
`default_nettype wire

// ----- sim/iec103_net_header_checker_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iec103_net_header_checker_test
// Feeds whole messages into the network header checker: a directed set that
// reaches every status and frame kind, then random well-formed, damaged and
// noise messages.
// Both channels idle at random; a separate checker predicts every report.
// ----------------------------------------------------------------------------
module iec103_net_header_checker_test;
  import nhc_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  localparam int unsigned RANDOM_BYTES = 1300;
  localparam logic [7:0]  S_CTRL_BYTE  = 8'h01;
  localparam logic [7:0]  U_MARK       = 8'h03;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatch_total;
  int   reports_due;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  int unsigned bytes_sent = 0;

  nhc_in_if  capture ();
  nhc_out_if report ();

  iec103_net_header_checker u_dut (
    .clk     (clk),
    .rst     (rst),
    .capture (capture),
    .report  (report)
  );

  nhc_report_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .capture     (capture),
    .report      (report),
    .mismatches  (mismatch_total),
    .outstanding (reports_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: a random number of idle cycles before each transfer, with
  // stretches where it never holds back.
  initial begin
    int unsigned gap;
    report.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        report.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      report.ready <= 1'b1;
      @(posedge clk);
      while (report.valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      capture.valid     <= 1'b0;
      capture.data_byte <= 8'($urandom);
      capture.last_byte <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    capture.valid     <= 1'b1;
    capture.data_byte <= b;
    capture.last_byte <= is_last;
    @(posedge clk);
    while (capture.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(input byte_q_t m);
    int unsigned i;
    for (i = 0; i < m.size(); i++) send_byte(m[i], i == m.size() - 1);
    bytes_sent += m.size();
    if ($urandom_range(0, 5) == 0) tx_quiet = !tx_quiet;
  endtask

  // Random body with the start byte, length field and control bytes in place.
  task automatic build_frame(output byte_q_t m, input int unsigned cap,
                             input logic [15:0] len_field,
                             input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2, input logic [7:0] c3);
    int unsigned i;
    m = {};
    for (i = 0; i < cap; i++) m.push_back(8'($urandom));
    m[0] = START_BYTE;
    m[1] = len_field[7:0];
    m[2] = len_field[15:8];
    m[3] = c0;
    m[4] = c1;
    m[5] = c2;
    m[6] = c3;
  endtask

  task automatic send_frame(input int unsigned cap, input logic [15:0] len_field,
                            input logic [7:0] c0, input logic [7:0] c1,
                            input logic [7:0] c2, input logic [7:0] c3);
    byte_q_t m;
    build_frame(m, cap, len_field, c0, c1, c2, c3);
    send_message(m);
  endtask

  task automatic random_message(output byte_q_t m);
    int unsigned pick, cap, i;
    logic [15:0] len_field;
    logic [7:0]  c0, c1, c2, c3;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      cap = $urandom_range(1, 30);
      m = {};
      for (i = 0; i < cap; i++) m.push_back(8'($urandom));
      if ($urandom_range(0, 1)) m[0] = START_BYTE;
      return;
    end
    c1 = 8'h00;
    c2 = 8'($urandom);
    c2[0] = 1'b0;
    c3 = 8'($urandom);
    len_field = 16'd12;
    case ($urandom_range(0, 2))
      0: begin
        cap = 15 + $urandom_range(0, 8);
        c0 = 8'($urandom);
        c0[0] = 1'b0;
        c1 = 8'($urandom);
        len_field = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(13, cap - 3))
                                                : 16'(cap - 3);
      end
      1: begin
        cap = ($urandom_range(0, 3) == 0) ? 15 + $urandom_range(1, 6) : 15;
        c0 = S_CTRL_BYTE;
      end
      default: begin
        cap = 15;
        c0 = (8'h04 << $urandom_range(0, 5)) | U_MARK;
        c2 = 8'h00;
        c3 = 8'h00;
      end
    endcase
    build_frame(m, cap, len_field, c0, c1, c2, c3);
    // About a third of the messages are damaged in one place.
    if (pick >= 70) begin
      case ($urandom_range(0, 6))
        0: m = m[0:$urandom_range(0, 13)];
        1: m[0] = 8'($urandom);
        2: {m[2], m[1]} = 16'(cap - 3 + $urandom_range(1, 8));
        3: m[3] = 8'($urandom);
        4: m[4 + $urandom_range(0, 2)] = 8'($urandom);
        5: m[5] = m[5] | 8'h01;
        default: {m[2], m[1]} = 16'($urandom_range(0, cap - 3));
      endcase
    end
  endtask

  initial begin
    byte_q_t m;
    int unsigned k;
    capture.valid     = 1'b0;
    capture.data_byte = 8'h00;
    capture.last_byte = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Lengths and start byte.
    m = '{START_BYTE};
    send_message(m);
    send_frame(14, 16'd11, 8'h00, 8'h00, 8'h00, 8'h00);
    build_frame(m, 15, 16'd12, 8'h00, 8'h00, 8'h00, 8'h00);
    m[0] = 8'hFF;
    send_message(m);
    send_frame(15, 16'd13, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(20, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);

    // I frames: all-ones fields with the full ASDU head, all-zero header,
    // odd receive number, partial ASDU heads.
    build_frame(m, 19, 16'd16, 8'hFE, 8'hFF, 8'hFE, 8'hFF);
    for (k = 7; k < 19; k++) m[k] = 8'hFF;
    send_message(m);
    build_frame(m, 15, 16'd12, 8'h00, 8'h00, 8'h00, 8'h00);
    for (k = 7; k < 15; k++) m[k] = 8'h00;
    send_message(m);
    send_frame(20, 16'd17, 8'h02, 8'h00, 8'h01, 8'h00);
    send_frame(16, 16'd13, 8'h10, 8'h20, 8'h30, 8'h40);
    send_frame(17, 16'd14, 8'h12, 8'h34, 8'h56, 8'h78);
    send_frame(18, 16'd15, 8'hAA, 8'h55, 8'hAA, 8'h55);
    send_frame(20, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);

    // S frames: good, each control fault, wrong length, capture past header.
    send_frame(15, 16'd12, S_CTRL_BYTE, 8'h00, 8'hFE, 8'hFF);
    send_frame(15, 16'd12, 8'hFD, 8'h00, 8'h00, 8'h00);
    send_frame(15, 16'd12, S_CTRL_BYTE, 8'h80, 8'h00, 8'h00);
    send_frame(15, 16'd12, S_CTRL_BYTE, 8'h00, 8'h03, 8'h00);
    send_frame(20, 16'd14, S_CTRL_BYTE, 8'h00, 8'h00, 8'h00);
    send_frame(19, 16'd12, S_CTRL_BYTE, 8'h00, 8'h00, 8'h80);

    // U frames: no function, several functions, length, control bytes, and
    // each single function.
    send_frame(15, 16'd12, U_MARK, 8'h00, 8'h00, 8'h00);
    send_frame(15, 16'd12, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_frame(16, 16'd13, 8'h07, 8'h00, 8'h00, 8'h00);
    send_frame(15, 16'd12, 8'h0B, 8'h00, 8'h00, 8'h01);
    for (k = 0; k < 6; k++) send_frame(15, 16'd12, (8'h04 << k) | U_MARK, 8'h00, 8'h00, 8'h00);

    // Hold the byte stream until every report of the directed part is in.
    capture.valid <= 1'b0;
    wait (reports_due == 0);
    @(negedge clk);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      random_message(m);
      send_message(m);
    end

    send_frame(19, 16'd16, 8'h00, 8'h00, 8'h00, 8'h00);

    capture.valid <= 1'b0;
    wait (reports_due == 0);
    repeat (20) @(posedge clk);
    if (mismatch_total == 0 && reports_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
